/* rtl/core/ptca_pkg.sv */
// ----------------------------------------------------------------------------
// ptca_pkg
// shared types and codes for the per-track collision alert hysteresis unit
// ----------------------------------------------------------------------------
package ptca_pkg;

  // operation codes of an input request
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_DROP   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_RAISE_TTC   = 2'd0;
  localparam logic [1:0] CFG_CLEAR_TTC   = 2'd1;
  localparam logic [1:0] CFG_RAISE_COUNT = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] RAISE_TTC_RST   = 16'd512;
  localparam logic [15:0] CLEAR_TTC_RST   = 16'd768;
  localparam logic [7:0]  RAISE_COUNT_RST = 8'd3;

  // input request payload
  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] obj_id;
    logic               ttc_ok;
    logic [15:0]        ttc;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic       alert;
    logic       status;
    logic [4:0] tracks_in_use;
  } out_item_t;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    CMD_UPDATE,
    CMD_DROP,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] id;
    logic        ttc_ok;
    logic [15:0] ttc;
  } cmd_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [15:0] raise_ttc;
    logic [15:0] clear_ttc;
    logic [7:0]  raise_count;
  } cfg_t;

endpackage

/* rtl/core/ptca_front.sv */
// ----------------------------------------------------------------------------
// ptca_front
// accepts input requests, classifies them and queues commands for the back
// ----------------------------------------------------------------------------
module ptca_front
  import ptca_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item,
  output logic     cmd_avail,
  input  logic     cmd_take,
  output cmd_t     cmd_head
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cmd_new;
  logic       do_push;
  logic       do_pop;

  // classify the incoming request
  always_comb begin
    cmd_new.id     = in_item.obj_id;
    cmd_new.ttc_ok = in_item.ttc_ok;
    cmd_new.ttc    = in_item.ttc;
    case (in_item.op)
      OP_UPDATE: cmd_new.kind = in_item.obj_id[15] ? CMD_NOP : CMD_UPDATE;
      OP_DROP:   cmd_new.kind = CMD_DROP;
      OP_CLEAR:  cmd_new.kind = CMD_CLEAR;
      default:   cmd_new.kind = CMD_NOP;
    endcase
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_avail = (cnt_r != 2'd0);
  assign cmd_head  = q_mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_avail;

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) q_mem_r[wr_ptr_r] <= cmd_new;
  end

endmodule

/* rtl/core/ptca_rsp_q.sv */
// ----------------------------------------------------------------------------
// ptca_rsp_q
// two-entry result queue between the back end and the result ports
// ----------------------------------------------------------------------------
module ptca_rsp_q
  import ptca_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      rsp_push,
  input  out_item_t rsp_item,
  output logic      rsp_space,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  out_item_t  q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign rsp_space = (cnt_r != 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign out_item  = q_mem_r[rd_ptr_r];
  assign do_push   = rsp_push && rsp_space;
  assign do_pop    = pop && !empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) q_mem_r[wr_ptr_r] <= rsp_item;
  end

endmodule

/* rtl/core/ptca_back.sv */
// ----------------------------------------------------------------------------
// ptca_back
// track table and the sequencer that carries out one command at a time
// ----------------------------------------------------------------------------
module ptca_back
  import ptca_pkg::*;
#(
  parameter int MAX_TRACKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      cmd_avail,
  output logic      cmd_take,
  input  cmd_t      cmd_head,
  input  logic      rsp_space,
  output logic      rsp_push,
  output out_item_t rsp_item
);

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_EXEC
  } state_t;

  state_t                  state_r;
  cmd_t                    cmd_r;
  logic [MAX_TRACKS-1:0]   valid_r;
  logic [MAX_TRACKS-1:0]   match_r;
  logic [MAX_TRACKS-1:0]   free_r;
  logic                    hit_r;
  logic [IW-1:0]           hit_idx_r;
  logic                    free_any_r;
  logic [IW-1:0]           free_idx_r;
  logic [CW-1:0]           occ_r;
  logic [CW-1:0]           occ_nxt;

  logic [15:0]             id_mem_r    [MAX_TRACKS];
  logic [7:0]              cnt_mem_r   [MAX_TRACKS];
  logic                    alert_mem_r [MAX_TRACKS];

  logic                    hit_nxt;
  logic [IW-1:0]           hit_idx_nxt;
  logic                    free_any_nxt;
  logic [IW-1:0]           free_idx_nxt;
  logic [IW-1:0]           k_idx;
  logic [7:0]              cur_cnt;
  logic                    cur_alert;
  logic [7:0]              new_cnt;
  logic                    new_alert;
  logic [7:0]              inc_cnt;
  logic                    danger;
  logic                    release_alert;
  logic                    upd_write;
  logic [CW+4:0]           occ_ext;

  assign cmd_take = (state_r == S_IDLE) && cmd_avail && rsp_space;
  assign rsp_push = (state_r == S_EXEC);

  // lowest matching and lowest free entry
  always_comb begin
    hit_nxt      = 1'b0;
    hit_idx_nxt  = '0;
    free_any_nxt = 1'b0;
    free_idx_nxt = '0;
    for (int i = MAX_TRACKS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = IW'(i);
      end
      if (free_r[i]) begin
        free_any_nxt = 1'b1;
        free_idx_nxt = IW'(i);
      end
    end
  end

  // hysteresis update of the selected entry
  always_comb begin
    k_idx         = hit_r ? hit_idx_r : free_idx_r;
    cur_cnt       = hit_r ? cnt_mem_r[hit_idx_r] : 8'd0;
    cur_alert     = hit_r ? alert_mem_r[hit_idx_r] : 1'b0;
    danger        = cmd_r.ttc_ok && (cmd_r.ttc <= cfg.raise_ttc);
    release_alert = !cmd_r.ttc_ok || (cmd_r.ttc >= cfg.clear_ttc);
    inc_cnt       = (cur_cnt < cfg.raise_count) ? cur_cnt + 8'd1 : cur_cnt;
    new_cnt       = cur_cnt;
    new_alert     = cur_alert;
    if (cur_alert) begin
      if (release_alert) begin
        new_alert = 1'b0;
        new_cnt   = 8'd0;
      end
    end else if (danger) begin
      new_cnt   = inc_cnt;
      new_alert = (inc_cnt >= cfg.raise_count);
    end else begin
      new_cnt = 8'd0;
    end
  end

  // result and occupancy
  always_comb begin
    occ_nxt   = occ_r;
    upd_write = 1'b0;
    rsp_item  = '0;
    case (cmd_r.kind)
      CMD_UPDATE: begin
        if (hit_r || free_any_r) begin
          upd_write      = 1'b1;
          rsp_item.alert = new_alert;
          if (!hit_r) occ_nxt = occ_r + CW'(1);
        end else begin
          rsp_item.status = 1'b1;
        end
      end
      CMD_DROP: begin
        if (hit_r && (occ_r != '0)) occ_nxt = occ_r - CW'(1);
      end
      CMD_CLEAR: occ_nxt = '0;
      default: occ_nxt = occ_r;
    endcase
    occ_ext                = (CW + 5)'(occ_nxt);
    rsp_item.tracks_in_use = occ_ext[4:0];
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      occ_r      <= '0;
      hit_r      <= 1'b0;
      free_any_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_take) begin
            cmd_r   <= cmd_head;
            state_r <= S_MATCH;
          end
        end
        S_MATCH: begin
          for (int i = 0; i < MAX_TRACKS; i++) begin
            match_r[i] <= valid_r[i] && (id_mem_r[i] == cmd_r.id);
            free_r[i]  <= !valid_r[i];
          end
          state_r <= S_PICK;
        end
        S_PICK: begin
          hit_r      <= hit_nxt;
          hit_idx_r  <= hit_idx_nxt;
          free_any_r <= free_any_nxt;
          free_idx_r <= free_idx_nxt;
          state_r    <= S_EXEC;
        end
        S_EXEC: begin
          occ_r <= occ_nxt;
          case (cmd_r.kind)
            CMD_UPDATE: if (upd_write) valid_r[k_idx] <= 1'b1;
            CMD_DROP:   if (hit_r) valid_r[hit_idx_r] <= 1'b0;
            CMD_CLEAR:  valid_r <= '0;
            default:    valid_r <= valid_r;
          endcase
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if ((state_r == S_EXEC) && upd_write) begin
      id_mem_r[k_idx]    <= cmd_r.id;
      cnt_mem_r[k_idx]   <= new_cnt;
      alert_mem_r[k_idx] <= new_alert;
    end
  end

endmodule

/* rtl/core/per_track_collision_alert_hysteresis_unit.sv */
// ----------------------------------------------------------------------------
// per_track_collision_alert_hysteresis_unit
// per-track collision alert with on/off hysteresis over a table of tracks
// ----------------------------------------------------------------------------
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------
//   input    | push / full          | in_item  (op, obj_id, ttc_ok, ttc)
//   result   | pop / empty          | out_item (alert, status, tracks_in_use)
//   config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// the back sequencer takes each request through these steps: latch, compare all
// entries, pick lowest hit and free entry, update table and post result.
// a two-entry command queue and a two-entry result queue decouple the ends.
// synchronous active-low reset empties the table and loads register defaults.
// a full result queue holds the back end; config writes are always taken.
// ----------------------------------------------------------------------------
module per_track_collision_alert_hysteresis_unit
  import ptca_pkg::*;
#(
  parameter int MAX_TRACKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg_r;
  logic      cmd_avail;
  logic      cmd_take;
  cmd_t      cmd_head;
  logic      rsp_space;
  logic      rsp_push;
  out_item_t rsp_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.raise_ttc   <= RAISE_TTC_RST;
      cfg_r.clear_ttc   <= CLEAR_TTC_RST;
      cfg_r.raise_count <= RAISE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RAISE_TTC:   cfg_r.raise_ttc   <= cfg_data;
        CFG_CLEAR_TTC:   cfg_r.clear_ttc   <= cfg_data;
        CFG_RAISE_COUNT: cfg_r.raise_count <= cfg_data[7:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // front: accept and classify
  ptca_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .cmd_head  (cmd_head)
  );

  // back: table and sequencer
  ptca_back #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_avail (cmd_avail),
    .cmd_take  (cmd_take),
    .cmd_head  (cmd_head),
    .rsp_space (rsp_space),
    .rsp_push  (rsp_push),
    .rsp_item  (rsp_item)
  );

  // result queue
  ptca_rsp_q u_rsp_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_push  (rsp_push),
    .rsp_item  (rsp_item),
    .rsp_space (rsp_space),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
